/* hdl/htt_pkg.sv */
// Shared types, character codes and token codes for the header text tokenizer.
// No dependencies; the lexer, the result queue and the top level import this package.
package htt_pkg;

  // Token kinds carried in token_kind
  localparam logic [3:0] TK_EOF       = 4'd0;
  localparam logic [3:0] TK_SPACE     = 4'd1;
  localparam logic [3:0] TK_TAB       = 4'd2;
  localparam logic [3:0] TK_CRLF      = 4'd3;
  localparam logic [3:0] TK_CR        = 4'd4;
  localparam logic [3:0] TK_LF        = 4'd5;
  localparam logic [3:0] TK_COLON     = 4'd6;
  localparam logic [3:0] TK_COMMA     = 4'd7;
  localparam logic [3:0] TK_SLASH     = 4'd8;
  localparam logic [3:0] TK_BACKSLASH = 4'd9;
  localparam logic [3:0] TK_LT        = 4'd10;
  localparam logic [3:0] TK_GT        = 4'd11;
  localparam logic [3:0] TK_WORD      = 4'd12;
  localparam logic [3:0] TK_QUOTED    = 4'd13;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHAR     = 2'd1;
  localparam logic [1:0] ERR_QUOTE    = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LT        = 8'h3C;
  localparam logic [7:0] CH_GT        = 8'h3E;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_DASH      = 8'h2D;

  // Depth of the result queue
  localparam int unsigned RES_DEPTH   = 4;

  // One result transaction
  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       token_end;
    logic [1:0] error_code;
    logic       last_result;
  } result_t;

  // Results produced by one accepted item
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } lex_push_t;

  // Queue status towards the top level
  typedef struct packed {
    logic [2:0] level;
    logic       has_room;
  } queue_stat_t;

  // Letters, digits, '.', '-' and '_'
  function automatic logic is_word_byte(input logic [7:0] b);
    is_word_byte = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
                   (b >= 8'h30 && b <= 8'h39) || b == CH_DOT || b == CH_DASH ||
                   b == CH_UNDER;
  endfunction

  // Builds a result with last_result clear
  function automatic result_t mk_res(input logic [3:0] kind, input logic [7:0] b,
                                     input logic valid, input logic tend,
                                     input logic [1:0] err);
    result_t r;
    r.token_kind  = kind;
    r.text_byte   = b;
    r.byte_valid  = valid;
    r.token_end   = tend;
    r.error_code  = err;
    r.last_result = 1'b0;
    mk_res = r;
  endfunction

endpackage

/* hdl/htt_in_if.sv */
// Input channel of the tokenizer: one raw byte or the end-of-input mark.
// Depends on nothing.
interface htt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

/* hdl/htt_out_if.sv */
// Output channel of the tokenizer: one result transaction per handshake.
// Depends on nothing.
interface htt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] text_byte;
  logic       byte_valid;
  logic       token_end;
  logic [1:0] error_code;
  logic       last_result;

  modport source (output valid, output token_kind, output text_byte, output byte_valid,
                  output token_end, output error_code, output last_result, input ready);
  modport sink   (input valid, input token_kind, input text_byte, input byte_valid,
                  input token_end, input error_code, input last_result, output ready);
endinterface

/* hdl/htt_lexer.sv */
// Lexer core: scan mode register and the per-byte decode into zero, one or two results.
// Depends on htt_pkg.
module htt_lexer (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              end_of_input,
  output htt_pkg::lex_push_t push
);
  import htt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_SPACE, M_CR, M_WORD, M_QUOTE, M_ESC, M_ERR_CHAR, M_ERR_QUOTE
  } mode_t;

  mode_t   mode, mode_next;
  mode_t   fresh_mode;
  result_t fresh_res, pre_res;
  logic    fresh_has, pre_has, use_fresh;
  result_t r0, r1;
  logic [1:0] n;

  // Decode of a byte seen from the idle mode
  always_comb begin
    fresh_mode = M_IDLE;
    fresh_has  = 1'b1;
    fresh_res  = mk_res(TK_EOF, 8'h00, 1'b0, 1'b1, ERR_NONE);
    if (!end_of_input) begin
      case (in_byte)
        CH_SPACE: begin
          fresh_mode = M_SPACE;
          fresh_res.token_kind = TK_SPACE;
        end
        CH_TAB:       fresh_res.token_kind = TK_TAB;
        CH_CR: begin
          fresh_mode = M_CR;
          fresh_has  = 1'b0;
        end
        CH_LF:        fresh_res.token_kind = TK_LF;
        CH_COLON:     fresh_res.token_kind = TK_COLON;
        CH_COMMA:     fresh_res.token_kind = TK_COMMA;
        CH_SLASH:     fresh_res.token_kind = TK_SLASH;
        CH_BACKSLASH: fresh_res.token_kind = TK_BACKSLASH;
        CH_LT:        fresh_res.token_kind = TK_LT;
        CH_GT:        fresh_res.token_kind = TK_GT;
        CH_QUOTE: begin
          fresh_mode = M_QUOTE;
          fresh_has  = 1'b0;
        end
        default: begin
          if (is_word_byte(in_byte)) begin
            fresh_mode = M_WORD;
            fresh_res  = mk_res(TK_WORD, in_byte, 1'b1, 1'b0, ERR_NONE);
          end else begin
            fresh_mode = M_ERR_CHAR;
            fresh_res  = mk_res(TK_EOF, 8'h00, 1'b0, 1'b0, ERR_CHAR);
          end
        end
      endcase
    end
  end

  // Mode-dependent result ahead of, or instead of, the fresh decode
  always_comb begin
    pre_has   = 1'b0;
    pre_res   = mk_res(TK_EOF, 8'h00, 1'b0, 1'b0, ERR_NONE);
    use_fresh = 1'b0;
    mode_next = mode;
    case (mode)
      M_ERR_CHAR: begin
        pre_has = 1'b1;
        pre_res = mk_res(TK_EOF, 8'h00, 1'b0, 1'b0, ERR_CHAR);
      end
      M_ERR_QUOTE: begin
        pre_has = 1'b1;
        pre_res = mk_res(TK_EOF, 8'h00, 1'b0, 1'b0, ERR_QUOTE);
      end
      M_SPACE: begin
        // further spaces of a run are absorbed
        if (end_of_input || in_byte != CH_SPACE) begin
          use_fresh = 1'b1;
        end
      end
      M_CR: begin
        pre_has = 1'b1;
        if (!end_of_input && in_byte == CH_LF) begin
          pre_res   = mk_res(TK_CRLF, 8'h00, 1'b0, 1'b1, ERR_NONE);
          mode_next = M_IDLE;
        end else begin
          pre_res   = mk_res(TK_CR, 8'h00, 1'b0, 1'b1, ERR_NONE);
          use_fresh = 1'b1;
        end
      end
      M_WORD: begin
        pre_has = 1'b1;
        if (!end_of_input && is_word_byte(in_byte)) begin
          pre_res = mk_res(TK_WORD, in_byte, 1'b1, 1'b0, ERR_NONE);
        end else begin
          pre_res   = mk_res(TK_WORD, 8'h00, 1'b0, 1'b1, ERR_NONE);
          use_fresh = 1'b1;
        end
      end
      M_QUOTE: begin
        pre_has = 1'b1;
        if (end_of_input) begin
          pre_res   = mk_res(TK_EOF, 8'h00, 1'b0, 1'b0, ERR_QUOTE);
          mode_next = M_ERR_QUOTE;
        end else if (in_byte == CH_QUOTE) begin
          pre_res   = mk_res(TK_QUOTED, 8'h00, 1'b0, 1'b1, ERR_NONE);
          mode_next = M_IDLE;
        end else begin
          pre_res = mk_res(TK_QUOTED, in_byte, 1'b1, 1'b0, ERR_NONE);
          if (in_byte == CH_BACKSLASH) begin
            mode_next = M_ESC;
          end
        end
      end
      M_ESC: begin
        pre_has = 1'b1;
        if (end_of_input) begin
          pre_res   = mk_res(TK_EOF, 8'h00, 1'b0, 1'b0, ERR_QUOTE);
          mode_next = M_ERR_QUOTE;
        end else begin
          pre_res   = mk_res(TK_QUOTED, in_byte, 1'b1, 1'b0, ERR_NONE);
          mode_next = M_QUOTE;
        end
      end
      default: use_fresh = 1'b1;
    endcase
    if (use_fresh) begin
      mode_next = fresh_mode;
    end
  end

  // Pack the results in order and mark the final one
  always_comb begin
    r0 = pre_res;
    r1 = fresh_res;
    n  = 2'd0;
    if (pre_has) begin
      n = (use_fresh && fresh_has) ? 2'd2 : 2'd1;
    end else if (use_fresh && fresh_has) begin
      r0 = fresh_res;
      n  = 2'd1;
    end
    r0.last_result = (n == 2'd1);
    r1.last_result = 1'b1;
    push.n  = fire ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  // Scan mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
    end else if (fire) begin
      mode <= mode_next;
    end
  end

endmodule

/* hdl/htt_res_queue.sv */
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on htt_pkg.
module htt_res_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  htt_pkg::lex_push_t    push,
  input  logic                  pop,
  output htt_pkg::result_t      head,
  output logic                  head_valid,
  output htt_pkg::queue_stat_t  stat
);
  import htt_pkg::*;

  localparam int unsigned PW = $clog2(RES_DEPTH);

  result_t         q [RES_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     level, level_next;

  // Occupancy bookkeeping
  always_comb begin
    level_next = level + {1'b0, push.n} - {{PW{1'b0}}, pop};
  end

  assign head       = q[rd_ptr];
  assign head_valid = (level != '0);
  assign stat.level    = level;
  assign stat.has_room = (level <= (PW+1)'(RES_DEPTH - 2));

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      level <= level_next;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q[wr_ptr + PW'(1)] <= push.r1;
    end
  end

endmodule

/* hdl/header_text_tokenizer.sv */
// Header text tokenizer: one byte or end-of-input mark per input transaction, token
// results out. Items are accepted one per cycle while input ready is high; their results
// are written into the result queue. An item yields zero, one or two results, and the
// single result port moves one per cycle while the receiver is ready, so an item that
// ends a word or a CR and starts a new token costs two output transactions. A four-entry
// result queue sits between the lexer and the output; input ready drops while it holds
// more than two results. Errors are sticky until reset.
module header_text_tokenizer (
  input  logic      clk,
  input  logic      rst,
  htt_in_if.sink    in_ch,
  htt_out_if.source out_ch
);
  import htt_pkg::*;

  lex_push_t   push;
  result_t     head;
  logic        head_valid;
  queue_stat_t stat;
  logic        fire, pop;

  assign in_ch.ready = stat.has_room;
  assign fire        = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  htt_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .in_byte      (in_ch.in_byte),
    .end_of_input (in_ch.end_of_input),
    .push         (push)
  );

  htt_res_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .stat       (stat)
  );

  // Output port
  assign out_ch.valid       = head_valid;
  assign out_ch.token_kind  = head.token_kind;
  assign out_ch.text_byte   = head.text_byte;
  assign out_ch.byte_valid  = head.byte_valid;
  assign out_ch.token_end   = head.token_end;
  assign out_ch.error_code  = head.error_code;
  assign out_ch.last_result = head.last_result;

  // Queue never overfills
  a_level: assert property (@(posedge clk) disable iff (rst)
    stat.level <= 3'(RES_DEPTH))
    else $error("result queue overfilled");

  // Of a pair, only the second closes the item
  a_pair: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> !push.r0.last_result && push.r1.last_result)
    else $error("bad last_result in result pair");

  // Error results stand alone
  a_err: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.error_code != ERR_NONE |->
      head.last_result && !head.token_end && !head.byte_valid)
    else $error("malformed error result");

  // Content bytes only in words and quoted strings
  a_byte: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.byte_valid |->
      (head.token_kind == TK_WORD || head.token_kind == TK_QUOTED))
    else $error("content byte on wrong token kind");

endmodule
